### src/smm_pkg.sv
package smm_pkg;

    localparam int DATA_W = 32;
    localparam int FUNC_W = 2;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 4;
    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(8);

    localparam logic [FUNC_W-1:0] FUNC_WR_A    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_B    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RD_PROD = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP     = 2'd3;

    typedef logic [DATA_W-1:0] word_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctrl_t;

endpackage

### src/square_matrix_multiply.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+-----------------------------------------
// input    | s_valid / s_ready  | s_func, s_row, s_col, s_value
// result   | m_valid / m_ready  | m_product_value, m_index_error
// config   | cfg_wr_en          | cfg_wr_data (matrix size)
//
// Element write: stored on accept. Index error: result beat via ST_RESP and the
// output register. Product read of size n: ST_RUN, ST_DRAIN, ST_RESP, output register,
// one multiply-accumulate per cycle, bounded by the single read port of each
// operand memory.
// Reset (aresetn low, synchronous) clears control only; operand memories hold
// garbage until written. Size resets to 8.
// A stalled result does not block element writes; the next read or error beat
// waits until the output register frees.
module square_matrix_multiply #(
    parameter int MAX_SIZE = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [3:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [2:0]         s_row,
    input  logic [2:0]         s_col,
    input  logic signed [31:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_product_value,
    output logic               m_index_error
);

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SW    = ($clog2(MAX_SIZE + 1) > 4) ? $clog2(MAX_SIZE + 1) : 4;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    function automatic logic [AW-1:0] elem_addr(input logic [AW-1:0] r,
                                                 input logic [AW-1:0] c);
        return r * AW'(MAX_SIZE) + c;
    endfunction

    logic [3:0]          size_reg;
    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [KW-1:0]       k_reg;
    logic [SW-1:0]       n_reg;
    logic [2:0]          row_reg;
    logic [2:0]          col_reg;
    logic                err_reg;
    smm_pkg::word_t      res_reg;
    logic                m_valid_reg;
    smm_pkg::word_t      m_value_reg;
    logic                m_error_reg;
    smm_pkg::mac_ctrl_t  issue_ctrl_reg;

    logic [SW-1:0]       size_ext;
    logic [SW-1:0]       n_eff;
    logic                in_range;
    logic                accept;
    logic                last_k;
    logic                out_free;
    logic                a_wr_en;
    logic                b_wr_en;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       a_rd_addr;
    logic [AW-1:0]       b_rd_addr;
    logic                rd_en;
    smm_pkg::word_t      a_rd_data;
    smm_pkg::word_t      b_rd_data;
    logic                mac_done;
    smm_pkg::word_t      mac_acc;

    assign size_ext = SW'(size_reg);
    assign n_eff    = (size_ext > SW'(MAX_SIZE)) ? SW'(MAX_SIZE) : size_ext;
    assign in_range = (SW'(s_row) < n_eff) && (SW'(s_col) < n_eff);
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign last_k   = (SW'(k_reg) == n_reg - SW'(1));
    assign out_free = !m_valid_reg || m_ready;

    assign a_wr_en   = accept && in_range && (s_func == smm_pkg::FUNC_WR_A);
    assign b_wr_en   = accept && in_range && (s_func == smm_pkg::FUNC_WR_B);
    assign wr_addr   = elem_addr(AW'(s_row), AW'(s_col));
    assign rd_en     = (state_reg == ST_RUN);
    assign a_rd_addr = elem_addr(AW'(row_reg), AW'(k_reg));
    assign b_rd_addr = elem_addr(AW'(k_reg), AW'(col_reg));

    smm_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_a (
        .aclk    (aclk),
        .wr_en   (a_wr_en),
        .wr_addr (wr_addr),
        .wr_data (smm_pkg::word_t'(s_value)),
        .rd_en   (rd_en),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    smm_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_b (
        .aclk    (aclk),
        .wr_en   (b_wr_en),
        .wr_addr (wr_addr),
        .wr_data (smm_pkg::word_t'(s_value)),
        .rd_en   (rd_en),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    smm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl_i  (issue_ctrl_reg),
        .a_i     (a_rd_data),
        .b_i     (b_rd_data),
        .done_o  (mac_done),
        .acc_o   (mac_acc)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !in_range && (s_func != smm_pkg::FUNC_NOP)) begin
                    state_next = ST_RESP;
                end else if (accept && (s_func == smm_pkg::FUNC_RD_PROD)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_k) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mac_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            size_reg       <= smm_pkg::SIZE_RESET;
            m_valid_reg    <= 1'b0;
            issue_ctrl_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
            end
            if (state_reg == ST_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            issue_ctrl_reg.valid <= rd_en;
            issue_ctrl_reg.first <= (k_reg == '0);
            issue_ctrl_reg.last  <= last_k;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            row_reg <= s_row;
            col_reg <= s_col;
            n_reg   <= n_eff;
            err_reg <= !in_range;
            res_reg <= '0;
            k_reg   <= '0;
        end else if (state_reg == ST_RUN) begin
            k_reg <= k_reg + KW'(1);
        end else if (state_reg == ST_DRAIN && mac_done) begin
            res_reg <= mac_acc;
        end
        if (state_reg == ST_RESP && out_free) begin
            m_value_reg <= res_reg;
            m_error_reg <= err_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_product_value = m_value_reg;
    assign m_index_error   = m_error_reg;

    a_mac_done_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> state_reg == ST_DRAIN)
        else $error("mac done outside drain");

    a_write_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_wr_en || b_wr_en) |-> state_reg == ST_IDLE)
        else $error("operand write while busy");

    a_k_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> SW'(k_reg) < n_reg)
        else $error("term index past size");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_index_error) |-> m_product_value == '0)
        else $error("error beat with nonzero value");

    a_single_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && last_k) |=> state_reg == ST_DRAIN && !rd_en)
        else $error("read issued past last term");

endmodule

### src/smm_ram.sv
module smm_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  smm_pkg::word_t      wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output smm_pkg::word_t      rd_data
);

    smm_pkg::word_t mem [DEPTH];
    smm_pkg::word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/smm_mac.sv
module smm_mac (
    input  logic                aclk,
    input  logic                aresetn,
    input  smm_pkg::mac_ctrl_t  ctrl_i,
    input  smm_pkg::word_t      a_i,
    input  smm_pkg::word_t      b_i,
    output logic                done_o,
    output smm_pkg::word_t      acc_o
);

    smm_pkg::mac_ctrl_t ctrl_reg;
    smm_pkg::word_t     prod_reg;
    smm_pkg::word_t     acc_reg;
    smm_pkg::word_t     acc_next;
    logic               done_reg;

    // low 32 bits of the product are the same for signed and unsigned
    always_ff @(posedge aclk) begin
        prod_reg <= a_i * b_i;
        if (ctrl_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    always_comb begin
        acc_next = (ctrl_reg.first ? '0 : acc_reg) + prod_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            ctrl_reg <= ctrl_i;
            done_reg <= ctrl_reg.valid && ctrl_reg.last;
        end
    end

    assign done_o = done_reg;
    assign acc_o  = acc_reg;

endmodule
